@@ design/bdbq_pkg.sv @@
// Package for the block-delayed biquad cascade.
// Sizes, fixed-point widths, item codes, sequencer states and the MAC control struct.
// No dependencies.
`default_nettype none
package bdbq_pkg;
	localparam int BLOCK_LEN  = 16;
	localparam int MAX_STAGES = 4;
	localparam int N_COEF     = 5;
	localparam int N_HIST     = 4;
	localparam int COEF_DEPTH = N_COEF * MAX_STAGES;
	localparam int HIST_DEPTH = N_HIST * MAX_STAGES;
	localparam int POS_W      = $clog2(BLOCK_LEN);
	localparam int CNT_W      = $clog2(MAX_STAGES + 1);
	localparam int STG_W      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int COEF_AW    = $clog2(COEF_DEPTH);
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int CSEL_W     = $clog2(N_COEF);
	localparam int SAMP_W     = 16;
	localparam int COEF_W     = 32;
	localparam int VAL_W      = 32;
	localparam int FRAC_SHIFT = 29;
	localparam int PROD_W     = COEF_W + VAL_W;
	localparam int TERM_W     = PROD_W - FRAC_SHIFT;
	localparam int ACC_W      = TERM_W + 3;
	localparam int STEP_W     = 3;

	typedef enum logic [1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SAMP_RD,
		ST_APPEND,
		ST_RUN_RD,
		ST_RUN_LD,
		ST_STAGE,
		ST_RUN_WR,
		ST_DELIVER
	} state_t;

	typedef struct packed {
		logic clr;
		logic mul;
	} mac_ctl_t;
endpackage
`default_nettype wire

@@ design/bdbq_mac.sv @@
// Shared multiply-accumulate unit: one registered 32x32 product, floor shift, 38-bit sum.
// Depends on bdbq_pkg; the accumulator is saturated to 32 bits on its output.
`default_nettype none
module bdbq_mac import bdbq_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mac_ctl_t                 ctl,
	input  wire logic signed [COEF_W-1:0] opa,
	input  wire logic signed [VAL_W-1:0]  opb,
	output logic signed [VAL_W-1:0]       y
);
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

	logic signed [PROD_W-1:0] prod_s1;
	logic                     vld_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.mul;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_s1 <= opa * opb;
		end
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + term;
		end
	end

	// arithmetic shift of the product rounds toward minus infinity
	assign term = {{(ACC_W-TERM_W){prod_s1[PROD_W-1]}}, prod_s1[PROD_W-1:FRAC_SHIFT]};

	always_comb begin
		if (acc_q > SAT_HI) begin
			y = SAT_HI[VAL_W-1:0];
		end else if (acc_q < SAT_LO) begin
			y = SAT_LO[VAL_W-1:0];
		end else begin
			y = acc_q[VAL_W-1:0];
		end
	end
endmodule
`default_nettype wire

@@ design/block_delayed_biquad_cascade_unit.sv @@
// Top level of the block-delayed biquad cascade: sequencer, state memories, output register.
// Depends on bdbq_pkg and bdbq_mac.
//
// Input channel (in_valid/in_stall) carries one item: a sample, an append of one stage's
// five coefficients, or a clear. Output channel (out_valid/out_stall) returns exactly one
// result per item. A sample returns the filtered sample written one block (16 samples)
// earlier, zero until the first block has been filtered.
// A sample result goes through ST_SAMP_RD and ST_DELIVER into the output register, and
// the next item is taken once the sequencer is back in ST_IDLE. The sample that completes
// a block also filters the whole block before it returns: each sample of the block passes
// ST_RUN_RD, ST_RUN_LD, a run of ST_STAGE steps per stage and ST_RUN_WR. The single shared
// multiplier and the single write port of the history memory pace this: each stage takes
// five products and four history writes. An append writes its five coefficients one at a
// time in ST_APPEND; a clear, a rejected append or an unused code only needs delivery.
// The input stalls while an item is at work; a finished result sits in the output
// register, so the next item is taken while the receiver stalls, and a second result
// then holds the sequencer until the register drains.
// Reset clears the stage count, block position and the valid bits of the history and
// block memories, so all of them read as zero; no clearing pass is needed.
`default_nettype none
module block_delayed_biquad_cascade_unit import bdbq_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [1:0]               func,
	input  wire logic signed [SAMP_W-1:0] sample_in,
	input  wire logic signed [COEF_W-1:0] coef_b0,
	input  wire logic signed [COEF_W-1:0] coef_b1,
	input  wire logic signed [COEF_W-1:0] coef_b2,
	input  wire logic signed [COEF_W-1:0] coef_a1,
	input  wire logic signed [COEF_W-1:0] coef_a2,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [SAMP_W-1:0]      sample_out,
	output logic                          saturated,
	output logic                          rejected
);
	localparam logic [STEP_W-1:0] STEP_X    = 3'd1;
	localparam logic [STEP_W-1:0] STEP_H0   = 3'd2;
	localparam logic [STEP_W-1:0] STEP_H1   = 3'd3;
	localparam logic [STEP_W-1:0] STEP_H2   = 3'd4;
	localparam logic [STEP_W-1:0] STEP_H3   = 3'd5;
	localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;
	localparam logic [STEP_W-1:0] APP_LAST  = STEP_W'(N_COEF - 1);
	localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(BLOCK_LEN - 1);
	localparam logic signed [23:0] Q_HI = 24'sd32767;
	localparam logic signed [23:0] Q_LO = -24'sd32768;

	state_t state_q, state_d;

	logic [1:0]               func_q;
	logic signed [COEF_W-1:0] coef_q [N_COEF];
	logic [POS_W-1:0]         pos_q, n_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [STG_W-1:0]         stg_q;
	logic [STEP_W-1:0]        step_q;
	logic signed [VAL_W-1:0]  x_q, h0_q, h2_q;
	logic signed [SAMP_W-1:0] res_samp_q;
	logic                     res_sat_q, res_rej_q;
	logic                     out_valid_q;
	logic signed [SAMP_W-1:0] out_samp_q;
	logic                     out_sat_q, out_rej_q;
	logic [HIST_DEPTH-1:0]    hv_q;
	logic [BLOCK_LEN-1:0]     iv_q, ov_q;

	logic [COEF_W-1:0]        coef_mem [COEF_DEPTH];
	logic [VAL_W-1:0]         hist_mem [HIST_DEPTH];
	logic [SAMP_W-1:0]        in_mem   [BLOCK_LEN];
	logic [SAMP_W:0]          out_mem  [BLOCK_LEN];
	logic [COEF_W-1:0]        coef_rd_q;
	logic [VAL_W-1:0]         hist_rd_q;
	logic                     hist_rv_q;
	logic [SAMP_W-1:0]        in_rd_q;
	logic                     in_rv_q;
	logic [SAMP_W:0]          out_rd_q;
	logic                     out_rv_q;

	logic                     accept, load_out, full, last_stg;
	logic                     coef_we, hist_we, out_we;
	logic [COEF_AW-1:0]       coef_wa, coef_ra;
	logic [HIST_AW-1:0]       hist_wa, hist_ra;
	logic [VAL_W-1:0]         hist_wd;
	logic signed [VAL_W-1:0]  hist_data, mul_b, y;
	logic signed [VAL_W-1:0]  x_in;
	logic signed [VAL_W:0]    x_bias;
	logic signed [23:0]       q_full;
	logic signed [SAMP_W-1:0] q_sat;
	logic                     q_clip;
	mac_ctl_t                 mac_ctl;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign load_out = (state_q == ST_DELIVER) && (!out_valid_q || !out_stall);
	assign full     = (cnt_q >= CNT_W'(MAX_STAGES));
	assign last_stg = ({1'b0, stg_q} + CNT_W'(1)) == cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func == FUNC_SAMPLE) begin
						state_d = ST_SAMP_RD;
					end else if (func == FUNC_APPEND) begin
						state_d = full ? ST_DELIVER : ST_APPEND;
					end else begin
						state_d = ST_DELIVER;
					end
				end
			end
			ST_SAMP_RD: state_d = (pos_q == POS_LAST) ? ST_RUN_RD : ST_DELIVER;
			ST_APPEND:  state_d = (step_q == APP_LAST) ? ST_DELIVER : ST_APPEND;
			ST_RUN_RD:  state_d = ST_RUN_LD;
			ST_RUN_LD:  state_d = (cnt_q == '0) ? ST_RUN_WR : ST_STAGE;
			ST_STAGE: begin
				if (step_q == STEP_LAST && last_stg) begin
					state_d = ST_RUN_WR;
				end
			end
			ST_RUN_WR:  state_d = (n_q == POS_LAST) ? ST_DELIVER : ST_RUN_RD;
			ST_DELIVER: state_d = load_out ? ST_IDLE : ST_DELIVER;
			default:    state_d = ST_IDLE;
		endcase
	end

	// memory strobes, addresses and MAC control
	always_comb begin
		coef_we     = (state_q == ST_APPEND);
		coef_wa     = COEF_AW'(32'(cnt_q) * N_COEF + 32'(step_q));
		coef_ra     = COEF_AW'(32'(stg_q) * N_COEF + 32'(step_q));
		hist_ra     = HIST_AW'(32'(stg_q) * N_HIST + 32'(step_q - STEP_X) % N_HIST);
		hist_we     = 1'b0;
		hist_wa     = HIST_AW'(32'(stg_q) * N_HIST);
		hist_wd     = x_q;
		out_we      = (state_q == ST_RUN_WR);
		mac_ctl.clr = (state_q == ST_STAGE) && (step_q == '0);
		mac_ctl.mul = (state_q == ST_STAGE) && (step_q >= STEP_X) && (step_q <= STEP_H3);
		if (state_q == ST_STAGE) begin
			unique case (step_q)
				STEP_H0: begin
					hist_we = 1'b1;
				end
				STEP_H1: begin
					hist_we = 1'b1;
					hist_wa = HIST_AW'(32'(stg_q) * N_HIST + 1);
					hist_wd = h0_q;
				end
				STEP_H3: begin
					hist_we = 1'b1;
					hist_wa = HIST_AW'(32'(stg_q) * N_HIST + 3);
					hist_wd = h2_q;
				end
				STEP_LAST: begin
					hist_we = 1'b1;
					hist_wa = HIST_AW'(32'(stg_q) * N_HIST + 2);
					hist_wd = y;
				end
				default: hist_we = 1'b0;
			endcase
		end
	end

	assign hist_data = hist_rv_q ? signed'(hist_rd_q) : '0;
	assign mul_b     = (step_q == STEP_X) ? x_q : hist_data;
	assign x_in      = in_rv_q ? VAL_W'({{(VAL_W-SAMP_W-8){in_rd_q[SAMP_W-1]}}, in_rd_q, 8'd0})
	                           : '0;

	// divide by 256 toward zero, then clip to 16 bits
	assign x_bias = {x_q[VAL_W-1], x_q} + (x_q[VAL_W-1] ? (VAL_W+1)'(255) : '0);
	assign q_full = x_bias[VAL_W-1:8];
	always_comb begin
		q_clip = 1'b1;
		if (q_full > Q_HI) begin
			q_sat = Q_HI[SAMP_W-1:0];
		end else if (q_full < Q_LO) begin
			q_sat = Q_LO[SAMP_W-1:0];
		end else begin
			q_sat  = q_full[SAMP_W-1:0];
			q_clip = 1'b0;
		end
	end

	bdbq_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.opa    (signed'(coef_rd_q)),
		.opb    (mul_b),
		.y      (y)
	);

	// memories
	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_wa] <= coef_q[step_q[CSEL_W-1:0]];
		end
		coef_rd_q <= coef_mem[coef_ra];
		if (hist_we) begin
			hist_mem[hist_wa] <= hist_wd;
		end
		hist_rd_q <= hist_mem[hist_ra];
		if (accept && func == FUNC_SAMPLE) begin
			in_mem[pos_q] <= sample_in;
		end
		in_rd_q <= in_mem[n_q];
		if (out_we) begin
			out_mem[n_q] <= {q_clip, q_sat};
		end
		out_rd_q <= out_mem[pos_q];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			n_q         <= '0;
			cnt_q       <= '0;
			stg_q       <= '0;
			step_q      <= '0;
			hv_q        <= '0;
			iv_q        <= '0;
			ov_q        <= '0;
			hist_rv_q   <= 1'b0;
			in_rv_q     <= 1'b0;
			out_rv_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			hist_rv_q <= hv_q[hist_ra];
			in_rv_q   <= iv_q[n_q];
			out_rv_q  <= ov_q[pos_q];
			if (hist_we) begin
				hv_q[hist_wa] <= 1'b1;
			end
			if (out_we) begin
				ov_q[n_q] <= 1'b1;
			end
			if (accept && func == FUNC_SAMPLE) begin
				iv_q[pos_q] <= 1'b1;
			end
			if (accept && func == FUNC_CLEAR) begin
				cnt_q <= '0;
				pos_q <= '0;
			end
			if (accept) begin
				step_q <= '0;
			end
			unique case (state_q)
				ST_SAMP_RD: begin
					n_q   <= '0;
					pos_q <= (pos_q == POS_LAST) ? '0 : pos_q + POS_W'(1);
				end
				ST_APPEND: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == APP_LAST) begin
						cnt_q <= cnt_q + CNT_W'(1);
						pos_q <= '0;
						hv_q  <= '0;
						iv_q  <= '0;
						ov_q  <= '0;
					end
				end
				ST_RUN_LD: begin
					stg_q  <= '0;
					step_q <= '0;
				end
				ST_STAGE: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_LAST && !last_stg) begin
						stg_q <= stg_q + STG_W'(1);
					end
				end
				ST_RUN_WR: begin
					n_q <= n_q + POS_W'(1);
				end
				default: begin
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q     <= func;
			coef_q[0]  <= coef_b0;
			coef_q[1]  <= coef_b1;
			coef_q[2]  <= coef_b2;
			coef_q[3]  <= coef_a1;
			coef_q[4]  <= coef_a2;
			res_samp_q <= '0;
			res_sat_q  <= 1'b0;
			res_rej_q  <= (func == FUNC_APPEND) && full;
		end
		if (state_q == ST_SAMP_RD && out_rv_q) begin
			res_samp_q <= out_rd_q[SAMP_W-1:0];
			res_sat_q  <= out_rd_q[SAMP_W];
		end
		if (state_q == ST_RUN_LD) begin
			x_q <= x_in;
		end
		if (state_q == ST_STAGE) begin
			if (step_q == STEP_H0) begin
				h0_q <= hist_data;
			end
			if (step_q == STEP_H2) begin
				h2_q <= hist_data;
			end
			if (step_q == STEP_LAST) begin
				x_q <= y;
			end
		end
		if (load_out) begin
			// a non-sample item always reports a zero sample
			out_samp_q <= (func_q == FUNC_SAMPLE) ? res_samp_q : '0;
			out_sat_q  <= (func_q == FUNC_SAMPLE) && res_sat_q;
			out_rej_q  <= res_rej_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_samp_q;
	assign saturated  = out_sat_q;
	assign rejected   = out_rej_q;
endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Testbench for the block-delayed biquad cascade unit: directed and random items.
// Predicts each result with its own fixed-point cascade and checks every transfer.
// Depends on bdbq_pkg and block_delayed_biquad_cascade_unit.
module tb;
	import bdbq_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [SAMP_W-1:0] sample;
		logic                     sat;
		logic                     rej;
	} filt_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] func = '0;
	logic signed [SAMP_W-1:0] sample_in = '0;
	logic signed [COEF_W-1:0] coef_b0 = '0, coef_b1 = '0, coef_b2 = '0;
	logic signed [COEF_W-1:0] coef_a1 = '0, coef_a2 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SAMP_W-1:0] sample_out;
	logic saturated;
	logic rejected;

	block_delayed_biquad_cascade_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	int unsigned          n_stages;
	logic signed [63:0]   coefs [COEF_DEPTH];
	logic signed [63:0]   hist [HIST_DEPTH];
	logic signed [15:0]   in_blk [BLOCK_LEN];
	logic signed [15:0]   out_blk [BLOCK_LEN];
	logic                 out_clip [BLOCK_LEN];
	int unsigned          blk_pos;

	filt_res_t pending_results[$];
	int errors = 0;
	int mismatches = 0;
	int burst_left = 0;

	function automatic logic signed [63:0] floor_shift29(logic signed [63:0] v);
		return v >>> FRAC_SHIFT;
	endfunction

	function automatic void filter_block();
		logic signed [63:0] x, acc, q;
		int unsigned s;
		for (int n = 0; n < BLOCK_LEN; n++) begin
			if (n_stages == 0) begin
				out_blk[n] = in_blk[n];
				out_clip[n] = 1'b0;
				continue;
			end
			x = 64'(in_blk[n]) * 256;
			for (s = 0; s < n_stages; s++) begin
				acc = floor_shift29(coefs[5*s] * x)
					+ floor_shift29(coefs[5*s+1] * hist[4*s])
					+ floor_shift29(coefs[5*s+2] * hist[4*s+1])
					+ floor_shift29(coefs[5*s+3] * hist[4*s+2])
					+ floor_shift29(coefs[5*s+4] * hist[4*s+3]);
				if (acc > 64'sd2147483647) acc = 64'sd2147483647;
				if (acc < -64'sd2147483648) acc = -64'sd2147483648;
				hist[4*s+1] = hist[4*s];
				hist[4*s] = x;
				hist[4*s+3] = hist[4*s+2];
				hist[4*s+2] = acc;
				x = acc;
			end
			q = x / 256;
			out_clip[n] = 1'b0;
			if (q > 32767) begin
				q = 32767;
				out_clip[n] = 1'b1;
			end
			if (q < -32768) begin
				q = -32768;
				out_clip[n] = 1'b1;
			end
			out_blk[n] = q[15:0];
		end
	endfunction

	function automatic void predictor_reset();
		n_stages = 0;
		blk_pos = 0;
		foreach (hist[i]) hist[i] = '0;
		foreach (coefs[i]) coefs[i] = '0;
		foreach (in_blk[i]) begin
			in_blk[i] = '0;
			out_blk[i] = '0;
			out_clip[i] = 1'b0;
		end
	endfunction

	function automatic filt_res_t predict_item(logic [1:0] f, logic signed [15:0] smp,
			logic signed [31:0] c0, c1, c2, c3, c4);
		filt_res_t r;
		r = '0;
		case (f)
			FUNC_SAMPLE: begin
				in_blk[blk_pos] = smp;
				r.sample = out_blk[blk_pos];
				r.sat = out_clip[blk_pos];
				blk_pos++;
				if (blk_pos >= BLOCK_LEN) begin
					blk_pos = 0;
					filter_block();
				end
			end
			FUNC_APPEND: begin
				if (n_stages >= MAX_STAGES) begin
					r.rej = 1'b1;
				end else begin
					coefs[5*n_stages] = c0;
					coefs[5*n_stages+1] = c1;
					coefs[5*n_stages+2] = c2;
					coefs[5*n_stages+3] = c3;
					coefs[5*n_stages+4] = c4;
					n_stages++;
					foreach (hist[i]) hist[i] = '0;
					foreach (in_blk[i]) begin
						in_blk[i] = '0;
						out_blk[i] = '0;
						out_clip[i] = 1'b0;
					end
					blk_pos = 0;
				end
			end
			FUNC_CLEAR: begin
				n_stages = 0;
				blk_pos = 0;
			end
			default: ;
		endcase
		return r;
	endfunction

	// Drop valid and put random filler on the idle bus.
	task automatic idle_bus();
		in_valid <= 1'b0;
		func <= 2'($urandom);
		sample_in <= 16'($urandom);
	endtask

	// Drive one item and hold it until the transfer; gaps come between bursts.
	task automatic send_item(logic [1:0] f, logic signed [15:0] smp,
			logic signed [31:0] c0 = 0, c1 = 0, c2 = 0, c3 = 0, c4 = 0);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 2) != 0) begin
				idle_bus();
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		burst_left--;
		pending_results.push_back(predict_item(f, smp, c0, c1, c2, c3, c4));
		in_valid <= 1'b1;
		func <= f;
		sample_in <= smp;
		coef_b0 <= c0;
		coef_b1 <= c1;
		coef_b2 <= c2;
		coef_a1 <= c3;
		coef_a2 <= c4;
		do @(posedge clk); while (in_stall);
	endtask

	// Receiver stall pattern: phases of no stall, light and heavy stall.
	initial begin
		int mode;
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(20, 200)) begin
				@(posedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		filt_res_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("unexpected result %0d/%0b/%0b", sample_out, saturated, rejected);
			end else begin
				exp_r = pending_results.pop_front();
				if (exp_r.sample !== sample_out || exp_r.sat !== saturated ||
						exp_r.rej !== rejected) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
							exp_r.sample, exp_r.sat, exp_r.rej,
							sample_out, saturated, rejected);
				end
			end
		end
	end

	task automatic wait_drained();
		idle_bus();
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_coef();
		// mostly modest coefficients so filters stay stable, some anything
		case ($urandom_range(0, 4))
			0: return 32'($urandom);
			1: return $signed(32'($urandom_range(0, 1))) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed(32'($urandom_range(0, 32'h3fffffff))) - 32'sh20000000;
		endcase
	endfunction

	task automatic append_rand();
		send_item(FUNC_APPEND, 16'($urandom), rand_coef(), rand_coef(), rand_coef(),
			rand_coef(), rand_coef());
	endtask

	task automatic test_passthrough();
		send_item(FUNC_SAMPLE, 16'sh7fff);
		send_item(FUNC_SAMPLE, -16'sh8000);
		send_item(FUNC_SAMPLE, 16'sh5555);
		send_item(FUNC_SAMPLE, -16'sh5556);
		repeat (14) send_item(FUNC_SAMPLE, 16'($urandom));
		send_item(FUNC_UNUSED, 16'sh1234);
	endtask

	task automatic test_stages_and_full();
		// unity stage, then extreme gains to force clipping, then reject
		send_item(FUNC_APPEND, 0, 32'sh20000000, 0, 0, 0, 0);
		send_item(FUNC_APPEND, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh7fffffff, 32'sh80000000);
		send_item(FUNC_APPEND, 0, 32'sh80000000, 0, 0, 0, 0);
		send_item(FUNC_APPEND, 0, 32'sh20000000, 0, 0, 32'sh10000000, 0);
		send_item(FUNC_APPEND, 0, 1, 2, 3, 4, 5);
		repeat (34) send_item(FUNC_SAMPLE, $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000);
		send_item(FUNC_CLEAR, 0);
		repeat (20) send_item(FUNC_SAMPLE, 16'($urandom));
	endtask

	task automatic test_random();
		int r;
		for (int i = 0; i < 1100; i++) begin
			r = $urandom_range(0, 99);
			if (r < 3) send_item(FUNC_CLEAR, 16'($urandom));
			else if (r < 7) append_rand();
			else if (r < 8) send_item(FUNC_UNUSED, 16'($urandom), 32'($urandom));
			else send_item(FUNC_SAMPLE, 16'($urandom));
			if (i == 500) wait_drained();
		end
	endtask

	initial begin
		predictor_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough();
		test_stages_and_full();
		test_random();
		wait_drained();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#20000000;
		$display("*** FAILED ***");
		$finish;
	end
endmodule

@@ sim.f @@
design/bdbq_pkg.sv
design/bdbq_mac.sv
design/block_delayed_biquad_cascade_unit.sv
sim/tb.sv
